### sv/shil_pkg.sv
// ----------------------------------------------------------------------------
// shil_pkg
// shared widths, codes and defaults for the sorted hash index lookup
// ----------------------------------------------------------------------------
package shil_pkg;

	localparam int HASH_BITS       = 64;
	localparam int VALUE_BITS      = 32;
	localparam int INDEX_BITS      = 10;
	localparam int KEY_COUNT_BITS  = 11;
	localparam int CFG_DATA_BITS   = 32;
	localparam int CFG_INDEX_BITS  = 1;

	localparam int MAX_KEYS_DEF    = 1024;
	localparam int OFFSET_BITS_DEF = 32;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_KEY_COUNT   = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_TEXT_LENGTH = 1'b1;

	// item opcodes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

endpackage

### sv/sorted_hash_index_lookup_unit.sv
// ----------------------------------------------------------------------------
// sorted_hash_index_lookup_unit
// binary search over a sorted table of 64-bit key hashes with value offsets
// ----------------------------------------------------------------------------
// write word: busy never rises, no result
// lookup word: each probe is a table read, then a compare; probes up to
//   clog2(n+1) with n = min(key_count, MAX_KEYS); a hit on a slot that is not
//   the last also reads the next offset to get the length; result strobe done
//   is registered, and for an empty table it rises in the cycle after the edge
//   that takes the word
// one lookup at a time: busy stays high until the done cycle
// reset clears the sequencer and both config registers; table content is
//   undefined until written; results cannot be stalled
module sorted_hash_index_lookup_unit #(
	parameter int MAX_KEYS    = shil_pkg::MAX_KEYS_DEF,
	parameter int OFFSET_BITS = shil_pkg::OFFSET_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write port
	input  logic                                cfg_write,
	input  logic [shil_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [shil_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	// command word
	input  logic                                start,
	output logic                                busy,
	input  logic                                opcode,
	input  logic [shil_pkg::INDEX_BITS-1:0]     entry_index,
	input  logic [shil_pkg::HASH_BITS-1:0]      key_hash,
	input  logic [shil_pkg::VALUE_BITS-1:0]     entry_offset,
	// result word
	output logic                                done,
	output logic                                found,
	output logic [shil_pkg::INDEX_BITS-1:0]     match_index,
	output logic [shil_pkg::VALUE_BITS-1:0]     value_offset,
	output logic [shil_pkg::VALUE_BITS-1:0]     value_length
);
	import shil_pkg::*;

	localparam int AW = $clog2(MAX_KEYS);          // table address bits
	localparam int CW = $clog2(MAX_KEYS + 1);      // count / bound bits
	localparam int LW = (OFFSET_BITS > VALUE_BITS) ? OFFSET_BITS : VALUE_BITS;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a command
	localparam logic [2:0] ST_READ = 3'd1;  // read slot at the midpoint
	localparam logic [2:0] ST_CMP  = 3'd2;  // compare probe with the key
	localparam logic [2:0] ST_NEXT = 3'd3;  // read offset of the following slot
	localparam logic [2:0] ST_LEN  = 3'd4;  // length from the following offset

	logic [2:0]              state_q;
	logic [KEY_COUNT_BITS-1:0] key_count_q;
	logic [VALUE_BITS-1:0]   text_length_q;

	// search registers
	logic [CW-1:0]           lo_q, hi_q, n_q;
	logic [AW-1:0]           mid_q;
	logic [HASH_BITS-1:0]    key_q;
	logic [OFFSET_BITS-1:0]  here_q;

	// result registers
	logic                    done_q, found_q;
	logic [INDEX_BITS-1:0]   match_index_q;
	logic [VALUE_BITS-1:0]   value_offset_q, value_length_q;

	// table ports
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic [HASH_BITS-1:0]    rd_hash;
	logic [OFFSET_BITS-1:0]  rd_offset;

	// combinational helpers
	logic                    accept;
	logic [CW-1:0]           n_c;
	logic [AW-1:0]           mid_c;
	logic [CW-1:0]           mid_ext, mid_inc;
	logic                    hit, probe_gt;
	logic [CW-1:0]           lo_n, hi_n;
	logic                    has_next;
	logic [LW-1:0]           span_end, span_start, span_len;
	logic [OFFSET_BITS-1:0]  here_c;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// slots at or above the table depth are dropped on write
	assign wr_en   = accept && (opcode == OP_WRITE)
		&& ({22'd0, entry_index} < 32'(MAX_KEYS));
	assign wr_addr = AW'({22'd0, entry_index});

	// clamp key_count to the table depth
	assign n_c = ({21'd0, key_count_q} > 32'(MAX_KEYS)) ? CW'(MAX_KEYS)
		: CW'({21'd0, key_count_q});

	// midpoint of the live range, always below n
	assign mid_c   = AW'(lo_q + ((hi_q - lo_q) >> 1));
	assign mid_ext = CW'({{(32 - AW){1'b0}}, mid_q});
	assign mid_inc = mid_ext + CW'(1);

	// shared 64-bit compare
	assign hit      = (rd_hash == key_q);
	assign probe_gt = (rd_hash > key_q);
	assign lo_n     = probe_gt ? lo_q : mid_inc;
	assign hi_n     = probe_gt ? mid_ext : hi_q;
	assign has_next = (mid_inc < n_q);

	// one subtractor serves both length cases, negative spans clamp to 0
	assign here_c     = (state_q == ST_LEN) ? here_q : rd_offset;
	assign span_end   = (state_q == ST_LEN) ? LW'(rd_offset) : LW'(text_length_q);
	assign span_start = LW'(here_c);
	assign span_len   = (span_end >= span_start) ? (span_end - span_start) : '0;

	assign rd_en   = (state_q == ST_READ) || (state_q == ST_NEXT);
	assign rd_addr = (state_q == ST_NEXT) ? AW'(mid_inc) : mid_c;

	shil_store #(
		.DEPTH (MAX_KEYS),
		.OBITS (OFFSET_BITS),
		.AW    (AW)
	) u_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_hash   (key_hash),
		.wr_offset (OFFSET_BITS'({{(LW - VALUE_BITS){1'b0}}, entry_offset})),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_hash   (rd_hash),
		.rd_offset (rd_offset)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q   <= '0;
			text_length_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_KEY_COUNT:   key_count_q   <= cfg_data[KEY_COUNT_BITS-1:0];
				CFG_TEXT_LENGTH: text_length_q <= cfg_data[VALUE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (opcode == OP_LOOKUP)) begin
						// empty table answers at once
						if (n_c == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: state_q <= ST_CMP;
				ST_CMP: begin
					if (hit) begin
						if (has_next) begin
							state_q <= ST_NEXT;
						end else begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
						end
					end else if (hi_n > lo_n) begin
						state_q <= ST_READ;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_NEXT: state_q <= ST_LEN;
				ST_LEN: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// search datapath and result word
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (opcode == OP_LOOKUP)) begin
					lo_q           <= '0;
					hi_q           <= n_c;
					n_q            <= n_c;
					key_q          <= key_hash;
					found_q        <= 1'b0;
					match_index_q  <= '0;
					value_offset_q <= '0;
					value_length_q <= '0;
				end
			end
			ST_READ: mid_q <= mid_c;
			ST_CMP: begin
				here_q <= rd_offset;
				if (hit) begin
					found_q        <= 1'b1;
					match_index_q  <= INDEX_BITS'({{(32 - AW){1'b0}}, mid_q});
					value_offset_q <= VALUE_BITS'(LW'(rd_offset));
					value_length_q <= VALUE_BITS'(span_len);
				end else begin
					lo_q <= lo_n;
					hi_q <= hi_n;
				end
			end
			ST_LEN: value_length_q <= VALUE_BITS'(span_len);
			default: ;
		endcase
	end

	assign done         = done_q;
	assign found        = found_q;
	assign match_index  = match_index_q;
	assign value_offset = value_offset_q;
	assign value_length = value_length_q;

`ifndef SYNTHESIS
	// a result always closes the lookup, the unit is free in that cycle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while sequencer still busy");

	// a miss carries an all-zero payload
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (match_index == '0 && value_offset == '0
			&& value_length == '0))
		else $error("miss result with nonzero payload");

	// a table write never starts the sequencer and never gives a result
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_WRITE) |=> (!busy && !done))
		else $error("write word caused activity");

	// a lookup either answers at once or starts searching
	a_lookup_go: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_LOOKUP) |=> (busy || done))
		else $error("lookup word dropped");
`endif

endmodule

### sv/shil_store.sv
// ----------------------------------------------------------------------------
// shil_store
// hash and offset table, one write port and one registered read port
// ----------------------------------------------------------------------------
module shil_store #(
	parameter int DEPTH = shil_pkg::MAX_KEYS_DEF,
	parameter int OBITS = shil_pkg::OFFSET_BITS_DEF,
	parameter int AW    = $clog2(shil_pkg::MAX_KEYS_DEF)
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [AW-1:0]                  wr_addr,
	input  logic [shil_pkg::HASH_BITS-1:0] wr_hash,
	input  logic [OBITS-1:0]               wr_offset,
	input  logic                           rd_en,
	input  logic [AW-1:0]                  rd_addr,
	output logic [shil_pkg::HASH_BITS-1:0] rd_hash,
	output logic [OBITS-1:0]               rd_offset
);
	import shil_pkg::*;

	logic [HASH_BITS-1:0] hash_mem [DEPTH];
	logic [OBITS-1:0]     offset_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			hash_mem[wr_addr]   <= wr_hash;
			offset_mem[wr_addr] <= wr_offset;
		end
	end

	// read data registered, valid the cycle after the address
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_hash   <= hash_mem[rd_addr];
			rd_offset <= offset_mem[rd_addr];
		end
	end

endmodule
